/* rtl/rarsm_pkg.sv */
// ----------------------------------------------------------------------------
// rarsm_pkg
// Shared types and constants for the rotating array range sum / min replace
// block: actions, controller states and the command / status groups.
// ----------------------------------------------------------------------------
package rarsm_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam logic [29:0] VALUE_CAP = 30'd999999999;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ROTATE  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_SUM     = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_OINIT,
    S_ODIV,
    S_AINIT,
    S_ADIV,
    S_ROT,
    S_SINIT,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_init_off;
    logic div_init_amt;
    logic div_step;
    logic off_from_rem;
    logic rot_apply;
    logic scan_init;
    logic scan_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    range_bad;
    logic    load_bad;
    logic    div_last;
    logic    scan_last;
  } stat_t;

endpackage

/* rtl/rarsm_ram.sv */
// ----------------------------------------------------------------------------
// rarsm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rarsm_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/rarsm_ctrl.sv */
// ----------------------------------------------------------------------------
// rarsm_ctrl
// Controller: sequences capture, modulo reduction, rotation, the range scan
// and the final result cycle.
// ----------------------------------------------------------------------------
module rarsm_ctrl
  import rarsm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.act == ACT_LOAD) begin
          state_next = S_FIN;
        end else if (stat.act == ACT_ROTATE || !stat.range_bad) begin
          state_next = S_OINIT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_OINIT: state_next = S_ODIV;
      S_ODIV:  if (stat.div_last) begin
        state_next = (stat.act == ACT_ROTATE) ? S_AINIT : S_SINIT;
      end
      S_AINIT: state_next = S_ADIV;
      S_ADIV:  if (stat.div_last) state_next = S_ROT;
      S_ROT:   state_next = S_FIN;
      S_SINIT: state_next = S_SCAN;
      S_SCAN:  if (stat.scan_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_CHECK: ;
      S_OINIT: cmd.div_init_off = 1'b1;
      S_ODIV:  cmd.div_step = 1'b1;
      S_AINIT: begin
        cmd.off_from_rem = 1'b1;
        cmd.div_init_amt = 1'b1;
      end
      S_ADIV:  cmd.div_step = 1'b1;
      S_ROT:   cmd.rot_apply = 1'b1;
      S_SINIT: begin
        cmd.off_from_rem = 1'b1;
        cmd.scan_init    = 1'b1;
      end
      S_SCAN:  cmd.scan_step = 1'b1;
      S_DRAIN: ;
      S_FIN:   cmd.fin = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/rarsm_dp.sv */
// ----------------------------------------------------------------------------
// rarsm_dp
// Datapath: request registers, length register, rotation offset, a
// bit-serial remainder unit, the element RAM and the scan accumulators.
// ----------------------------------------------------------------------------
module rarsm_dp
  import rarsm_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  action,
  input  logic [10:0] range_start,
  input  logic [10:0] range_end,
  input  logic [29:0] new_value,
  input  logic [31:0] rotate_amount,
  input  logic        cfg_valid,
  input  logic [10:0] cfg_data,
  output logic        done,
  output logic [39:0] range_total,
  output logic [10:0] replaced_slot,
  output logic        status
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = $clog2(DIV_STEPS);

  action_t      act;
  logic [10:0]  s_q, e_q, k;
  logic [29:0]  v_q;
  logic [31:0]  amt_q, quo;
  logic [LW-1:0] n, off, rem;
  logic [CW-1:0] div_cnt;
  logic [AW-1:0] p, rd_pos, best_pos;
  logic          rvalid, first;
  logic [29:0]   rdata, best_val;
  logic [39:0]   sum;
  logic [LW:0]   rem_sh, rem_new, off_sum, p0_sum;
  logic [31:0]   cfg_ext, n_ext;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign n_ext   = 32'(n);
  assign cfg_ext = 32'(cfg_data);

  assign stat.act       = act;
  assign stat.range_bad = (s_q == '0) || (s_q > e_q) || (32'(e_q) > n_ext);
  assign stat.load_bad  = (s_q == '0) || (32'(s_q) > n_ext);
  assign stat.div_last  = (div_cnt == CW'(DIV_STEPS - 1));
  assign stat.scan_last = (k == e_q);

  // one restoring remainder step
  assign rem_sh  = {rem, quo[31]};
  assign rem_new = (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;

  assign off_sum = {1'b0, off} + {1'b0, rem};
  // physical index of range_start, with the reduced offset in rem
  assign p0_sum  = (LW + 1)'(32'(s_q) - 32'd1) + ({1'b0, n} - {1'b0, rem});

  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= LW'(MAX_LEN);
      off <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_ext == 32'd0) begin
          n <= LW'(1);
        end else if (cfg_ext > 32'(MAX_LEN)) begin
          n <= LW'(MAX_LEN);
        end else begin
          n <= LW'(cfg_ext);
        end
      end
      if (cmd.off_from_rem) begin
        off <= rem;
      end else if (cmd.rot_apply) begin
        off <= (off_sum >= {1'b0, n}) ? LW'(off_sum - {1'b0, n}) : LW'(off_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act   <= action_t'(action);
      s_q   <= range_start;
      e_q   <= range_end;
      v_q   <= (new_value > VALUE_CAP) ? VALUE_CAP : new_value;
      amt_q <= rotate_amount;
    end
    if (cmd.div_init_off || cmd.div_init_amt) begin
      rem     <= '0;
      div_cnt <= '0;
      quo     <= cmd.div_init_amt ? amt_q : 32'(off);
    end else if (cmd.div_step) begin
      rem     <= LW'(rem_new);
      quo     <= {quo[30:0], 1'b0};
      div_cnt <= div_cnt + CW'(1);
    end
    if (cmd.scan_init) begin
      p     <= (p0_sum >= {1'b0, n}) ? AW'(p0_sum - {1'b0, n}) : AW'(p0_sum);
      k     <= s_q;
      sum   <= '0;
      first <= 1'b1;
    end else begin
      if (cmd.scan_step) begin
        p <= (32'(p) + 32'd1 == n_ext) ? '0 : p + AW'(1);
        k <= k + 11'd1;
      end
      if (rvalid) begin
        sum   <= sum + 40'(rdata);
        first <= 1'b0;
        // strict compare keeps the leftmost minimum
        if (first || rdata < best_val) begin
          best_val <= rdata;
          best_pos <= rd_pos;
        end
      end
    end
    rd_pos <= p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      rvalid <= cmd.scan_step;
      done   <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      range_total   <= (act == ACT_SUM && !stat.range_bad) ? sum : '0;
      replaced_slot <= (act == ACT_REPLACE && !stat.range_bad) ?
                       11'(32'(best_pos) + 32'd1) : '0;
      case (act)
        ACT_LOAD:   status <= stat.load_bad;
        ACT_ROTATE: status <= 1'b0;
        default:    status <= stat.range_bad;
      endcase
    end
  end

  assign wr_en = cmd.fin && ((act == ACT_LOAD && !stat.load_bad) ||
                             (act == ACT_REPLACE && !stat.range_bad));
  assign wr_addr = (act == ACT_LOAD) ? AW'(32'(s_q) - 32'd1) : best_pos;

  rarsm_ram #(
    .WIDTH(30),
    .DEPTH(MAX_LEN)
  ) u_elem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(v_q),
    .rd_addr(p),
    .rd_data(rdata)
  );

endmodule

/* rtl/rotating_array_range_sum_min_replace.sv */
// load: writes one element unless its index is bad; rotate: two 32-step remainders
// range sum / replace-min: one 32-step remainder, then the element scan at one
// RAM read per cycle; a bad range finishes with neither remainder nor scan
// one request at a time: busy is high from accept until the result strobe
// synchronous reset clears the offset, sets the length to MAX_LEN; RAM is unset
// ----------------------------------------------------------------------------
// rotating_array_range_sum_min_replace
// Circular array with rotation, range sum and range-minimum replacement.
// ----------------------------------------------------------------------------
module rotating_array_range_sum_min_replace
  import rarsm_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [10:0] range_start,
  input  logic [10:0] range_end,
  input  logic [29:0] new_value,
  input  logic [31:0] rotate_amount,
  output logic        done,
  output logic [39:0] range_total,
  output logic [10:0] replaced_slot,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rarsm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  rarsm_dp #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .range_start  (range_start),
    .range_end    (range_end),
    .new_value    (new_value),
    .rotate_amount(rotate_amount),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .done         (done),
    .range_total  (range_total),
    .replaced_slot(replaced_slot),
    .status       (status)
  );

endmodule

/* rtl/rarsm_checker.sv */
// ----------------------------------------------------------------------------
// rarsm_checker
// Port-level checks on request sequencing and result strobes.
// ----------------------------------------------------------------------------
module rarsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [39:0] range_total,
  input logic [10:0] replaced_slot,
  input logic        status
);

  // a transfer makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    done && status |-> (range_total == '0) && (replaced_slot == '0))
    else $error("rejected request reported data");

endmodule

bind rotating_array_range_sum_min_replace rarsm_checker u_rarsm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .range_total  (range_total),
  .replaced_slot(replaced_slot),
  .status       (status)
);
